/* rtl/fis_pkg.sv */
// Types, constants and cell opcodes shared by the free interval subtractor.
package fis_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int POS_BITS    = 16;
    localparam int CNT_BITS    = $clog2(MAX_WINDOWS + 1);
    localparam int IDX_BITS    = $clog2(MAX_WINDOWS);
    localparam int FIELD_BITS  = 16;

    typedef logic [POS_BITS-1:0]   t_pos;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [FIELD_BITS-1:0] t_field;

    typedef struct packed {
        logic   has_obstacle;
        t_field edge_a;
        t_field edge_b;
        logic   last_of_scene;
    } t_req;

    typedef struct packed {
        t_field window_start;
        t_field window_end;
        logic   is_best;
        logic   no_window;
        logic   overflow;
        logic   last_window;
    } t_res;

    typedef struct packed {
        t_pos s;
        t_pos e;
    } t_window;

    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_OPEN    = 3'd1,
        OP_UPDATE  = 3'd2,
        OP_COMPACT = 3'd3,
        OP_ROTATE  = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_pos     lo;
        t_pos     hi;
        logic     room;
    } t_cell_ctl;

    typedef struct packed {
        logic active;
        logic shift;
        logic above;
        logic wrap;
    } t_lane;

endpackage

/* rtl/free_interval_subtractor_core.sv */
// Top level of the free interval subtractor: control, chain of window cells, result register.
//
//  channel   direction  handshake                       payload
//  request   in         start & !busy at rising edge    i_req  (t_req)
//  result    out        o_strobe, one cycle, no stall   o_res  (t_res)
//  config    in         i_cfg_we at rising edge         i_cfg_wdata (span_end)
//
// A request passes through S_UPDATE, then S_COMPACT, which removes killed windows one by one; the
// scene's last request adds a scan rotation of the cell chain, then an emit rotation, or a
// single emit step for an empty scene.
// Synchronous active-low reset clears the control state and sets span_end to 65535.
// Results leave on fixed cycles; the receiver cannot stall them.
module free_interval_subtractor_core import fis_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_req   i_req,
    input  logic   i_cfg_we,
    input  t_field i_cfg_wdata,
    output logic   o_strobe,
    output t_res   o_res
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_UPDATE  = 5'b00010,
        S_COMPACT = 5'b00100,
        S_SCAN    = 5'b01000,
        S_EMIT    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_scene_open, n_scene_open;
    logic   r_overflow, n_overflow;
    t_pos   r_span;
    t_pos   r_lo, n_lo;
    t_pos   r_hi, n_hi;
    logic   r_has, n_has;
    logic   r_last, n_last;
    t_idx   r_idx, n_idx;
    t_idx   r_best, n_best;
    t_pos   r_best_w, n_best_w;
    logic   r_strobe, n_strobe;
    t_res   r_res, n_res;

    t_cell_ctl ctl;
    t_window   win  [MAX_WINDOWS];
    logic [MAX_WINDOWS-1:0] kill_v;
    logic [MAX_WINDOWS-1:0] split_v;
    logic [MAX_WINDOWS-1:0] act_v;
    logic [MAX_WINDOWS-1:0] live_kill;
    logic [MAX_WINDOWS-1:0] low_kill;
    logic [MAX_WINDOWS-1:0] shift_v;
    logic [MAX_WINDOWS-1:0] above_v;
    logic [MAX_WINDOWS-1:0] wrap_v;
    t_window   base_win;
    t_pos      ea, eb;
    t_pos      head_w;
    logic      accept;
    logic      idx_last;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    assign base_win.s = '0;
    assign base_win.e = r_span;
    assign head_w     = win[0].e - win[0].s;
    assign idx_last   = (CNT_BITS'(r_idx) == (r_count - t_cnt'(1)));

    always_comb begin
        for (int j = 0; j < MAX_WINDOWS; j++) begin
            act_v[j]  = (CNT_BITS'(j) < r_count);
            wrap_v[j] = (CNT_BITS'(j) == (r_count - t_cnt'(1)));
        end
    end

    assign live_kill = kill_v & act_v;
    assign low_kill  = live_kill & (~live_kill + MAX_WINDOWS'(1));
    assign shift_v   = (live_kill != '0) ? ~(low_kill - MAX_WINDOWS'(1)) : '0;
    assign above_v   = (split_v != '0)
                     ? ~((split_v - MAX_WINDOWS'(1)) | split_v | (split_v << 1)) : '0;

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOWS; g++) begin : g_cell
            t_lane   lane;
            t_window prev_win;
            t_window next_win;
            logic    prev_split;
            logic    next_kill;

            assign lane.active = act_v[g];
            assign lane.shift  = shift_v[g];
            assign lane.above  = above_v[g];
            assign lane.wrap   = wrap_v[g];

            if (g == 0) begin : g_first
                assign prev_win   = base_win;
                assign prev_split = 1'b0;
            end else begin : g_mid
                assign prev_win   = win[g-1];
                assign prev_split = split_v[g-1];
            end

            if (g == MAX_WINDOWS - 1) begin : g_tail
                assign next_win  = win[g];
                assign next_kill = 1'b0;
            end else begin : g_body
                assign next_win  = win[g+1];
                assign next_kill = kill_v[g+1];
            end

            fis_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_lane       (lane),
                .i_prev       (prev_win),
                .i_prev_split (prev_split),
                .i_next       (next_win),
                .i_next_kill  (next_kill),
                .i_head       (win[0]),
                .o_win        (win[g]),
                .o_kill       (kill_v[g]),
                .o_split      (split_v[g])
            );
        end
    endgenerate

    always_comb begin
        ea = t_pos'(i_req.edge_a);
        eb = t_pos'(i_req.edge_b);
        if (ea > r_span) begin
            ea = r_span;
        end
        if (eb > r_span) begin
            eb = r_span;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scene_open = r_scene_open;
        n_overflow   = r_overflow;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_has        = r_has;
        n_last       = r_last;
        n_idx        = r_idx;
        n_best       = r_best;
        n_best_w     = r_best_w;
        n_strobe     = 1'b0;
        n_res        = r_res;
        ctl.op       = OP_HOLD;
        ctl.lo       = r_lo;
        ctl.hi       = r_hi;
        ctl.room     = (r_count < t_cnt'(MAX_WINDOWS));

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!r_scene_open) begin
                        ctl.op       = OP_OPEN;
                        n_count      = (r_span != '0) ? t_cnt'(1) : '0;
                        n_overflow   = 1'b0;
                        n_scene_open = 1'b1;
                    end
                    n_lo    = (ea < eb) ? ea : eb;
                    n_hi    = (ea < eb) ? eb : ea;
                    n_has   = i_req.has_obstacle && (ea != eb);
                    n_last  = i_req.last_of_scene;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_has) begin
                    ctl.op = OP_UPDATE;
                    if (split_v != '0) begin
                        if (ctl.room) begin
                            n_count = r_count + t_cnt'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end
                end
                n_state = S_COMPACT;
            end
            S_COMPACT: begin
                if (live_kill != '0) begin
                    ctl.op  = OP_COMPACT;
                    n_count = r_count - t_cnt'(1);
                end else if (r_last) begin
                    n_scene_open = 1'b0;
                    n_idx        = '0;
                    n_state      = (r_count != '0) ? S_SCAN : S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                ctl.op = OP_ROTATE;
                if ((r_idx == '0) || (head_w > r_best_w)) begin
                    n_best   = r_idx;
                    n_best_w = head_w;
                end
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + t_idx'(1);
                end
            end
            S_EMIT: begin
                n_strobe           = 1'b1;
                n_res.overflow     = r_overflow;
                if (r_count == '0) begin
                    n_res.window_start = '0;
                    n_res.window_end   = '0;
                    n_res.is_best      = 1'b0;
                    n_res.no_window    = 1'b1;
                    n_res.last_window  = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    ctl.op             = OP_ROTATE;
                    n_res.window_start = FIELD_BITS'(win[0].s);
                    n_res.window_end   = FIELD_BITS'(win[0].e);
                    n_res.is_best      = (r_idx == r_best);
                    n_res.no_window    = 1'b0;
                    n_res.last_window  = idx_last;
                    n_idx              = r_idx + t_idx'(1);
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_scene_open <= 1'b0;
            r_overflow   <= 1'b0;
            r_strobe     <= 1'b0;
            r_has        <= 1'b0;
            r_last       <= 1'b0;
            r_idx        <= '0;
            r_span       <= t_pos'(16'hFFFF);
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_scene_open <= n_scene_open;
            r_overflow   <= n_overflow;
            r_strobe     <= n_strobe;
            r_has        <= n_has;
            r_last       <= n_last;
            r_idx        <= n_idx;
            if (i_cfg_we) begin
                r_span <= t_pos'(i_cfg_wdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_best   <= n_best;
        r_best_w <= n_best_w;
        r_res    <= n_res;
    end

endmodule

/* rtl/fis_cell.sv */
// One window cell of the chain: holds a window and updates it from its neighbors.
module fis_cell import fis_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_lane     i_lane,
    input  t_window   i_prev,
    input  logic      i_prev_split,
    input  t_window   i_next,
    input  logic      i_next_kill,
    input  t_window   i_head,
    output t_window   o_win,
    output logic      o_kill,
    output logic      o_split
);

    t_window r_win;
    t_window n_win;
    logic    r_kill;
    logic    n_kill;
    logic    covered;
    logic    trim_end;
    logic    trim_start;

    assign covered    = (i_ctl.lo <= r_win.s) && (i_ctl.hi >= r_win.e);
    assign trim_end   = (i_ctl.lo > r_win.s) && (i_ctl.lo < r_win.e);
    assign trim_start = (i_ctl.hi > r_win.s) && (i_ctl.hi < r_win.e);
    assign o_split    = i_lane.active && (i_ctl.lo > r_win.s) && (i_ctl.hi < r_win.e);
    assign o_win      = r_win;
    assign o_kill     = r_kill;

    always_comb begin
        n_win  = r_win;
        n_kill = r_kill;
        case (i_ctl.op)
            OP_OPEN: begin
                n_win  = i_prev;
                n_kill = 1'b0;
            end
            OP_UPDATE: begin
                n_kill = 1'b0;
                if (o_split) begin
                    n_win.e = i_ctl.lo;
                end else if (i_prev_split) begin
                    if (i_ctl.room) begin
                        n_win.s = i_ctl.hi;
                        n_win.e = i_prev.e;
                    end
                end else if (i_lane.above) begin
                    if (i_ctl.room) begin
                        n_win = i_prev;
                    end
                end else if (i_lane.active) begin
                    if (covered) begin
                        n_kill = 1'b1;
                    end else if (trim_end) begin
                        n_win.e = i_ctl.lo;
                    end else if (trim_start) begin
                        n_win.s = i_ctl.hi;
                    end
                end
            end
            OP_COMPACT: begin
                if (i_lane.shift) begin
                    n_win  = i_next;
                    n_kill = i_next_kill;
                end
            end
            OP_ROTATE: begin
                n_win = i_lane.wrap ? i_head : i_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kill <= 1'b0;
        end else begin
            r_kill <= n_kill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

/* bench/free_interval_subtractor_core_tb.sv */
// Self-checking testbench for free_interval_subtractor_core with window prediction.
`timescale 1ns / 1ps

module free_interval_subtractor_core_tb import fis_pkg::*; ();

    localparam int SETTLE_CYCLES  = 80;
    localparam int PHASE_REQUESTS = 45;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_req   i_req;
    logic   i_cfg_we;
    t_field i_cfg_wdata;
    logic   o_strobe;
    t_res   o_res;

    t_pos win_lo [MAX_WINDOWS];
    t_pos win_hi [MAX_WINDOWS];
    t_pos span_cfg;
    int   win_cnt;
    bit   scene_live;
    bit   split_dropped;
    bit   gaps_on;
    int   error_count;
    t_res pending_windows [$];

    free_interval_subtractor_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic void cut_windows(input t_pos a, input t_pos b);
        t_pos lo;
        t_pos hi;
        t_pos s;
        t_pos e;
        t_pos ns [MAX_WINDOWS];
        t_pos ne [MAX_WINDOWS];
        int   n;
        if (a == b) return;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        n = 0;
        for (int i = 0; i < win_cnt; i++) begin
            s = win_lo[i];
            e = win_hi[i];
            if (!(lo <= s && hi >= e)) begin
                if (lo > s && hi < e) begin
                    if (n < MAX_WINDOWS) begin
                        ns[n] = s;
                        ne[n] = lo;
                        n++;
                    end
                    if (win_cnt < MAX_WINDOWS && n < MAX_WINDOWS) begin
                        ns[n] = hi;
                        ne[n] = e;
                        n++;
                    end else begin
                        split_dropped = 1'b1;
                    end
                end else begin
                    if (lo > s && lo < e) begin
                        e = lo;
                    end else if (hi > s && hi < e) begin
                        s = hi;
                    end
                    if (n < MAX_WINDOWS) begin
                        ns[n] = s;
                        ne[n] = e;
                        n++;
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            win_lo[i] = ns[i];
            win_hi[i] = ne[i];
        end
        win_cnt = n;
    endfunction

    function automatic void apply_request(input t_req r);
        t_pos a;
        t_pos b;
        t_res res;
        int   best;
        int   best_w;
        int   w;
        if (!scene_live) begin
            split_dropped = 1'b0;
            win_cnt = 0;
            if (span_cfg != 0) begin
                win_lo[0] = '0;
                win_hi[0] = span_cfg;
                win_cnt = 1;
            end
            scene_live = 1'b1;
        end
        if (r.has_obstacle) begin
            a = (r.edge_a > span_cfg) ? span_cfg : r.edge_a;
            b = (r.edge_b > span_cfg) ? span_cfg : r.edge_b;
            cut_windows(a, b);
        end
        if (!r.last_of_scene) return;
        scene_live = 1'b0;
        if (win_cnt == 0) begin
            res = '{window_start: '0, window_end: '0, is_best: 1'b0, no_window: 1'b1,
                    overflow: split_dropped, last_window: 1'b1};
            pending_windows.insert(pending_windows.size(), res);
            return;
        end
        best = 0;
        best_w = 0;
        for (int i = 0; i < win_cnt; i++) begin
            w = int'(win_hi[i]) - int'(win_lo[i]);
            if (i == 0 || w > best_w) begin
                best = i;
                best_w = w;
            end
        end
        for (int i = 0; i < win_cnt; i++) begin
            res = '{window_start: win_lo[i], window_end: win_hi[i], is_best: (i == best),
                    no_window: 1'b0, overflow: split_dropped,
                    last_window: (i + 1 == win_cnt)};
            pending_windows.insert(pending_windows.size(), res);
        end
    endfunction

    function automatic t_req make_req(input bit obs, input int unsigned a,
                                      input int unsigned b, input bit last);
        t_req r;
        r.has_obstacle  = obs;
        r.edge_a        = t_field'(a);
        r.edge_b        = t_field'(b);
        r.last_of_scene = last;
        return r;
    endfunction

    function automatic t_req random_req(input bit last);
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        t_req        r;
        span = span_cfg;
        r.has_obstacle  = ($urandom_range(0, 7) != 0);
        r.last_of_scene = last;
        case ($urandom_range(0, 5))
            0: begin
                r.edge_a = t_field'($urandom_range(0, 65535));
                r.edge_b = t_field'($urandom_range(0, 65535));
            end
            1: begin
                r.edge_a = t_field'($urandom_range(0, span));
                r.edge_b = r.edge_a;
            end
            2, 3: begin
                lo = $urandom_range(0, span);
                hi = lo + $urandom_range(1, span / 12 + 1);
                if (hi > 65535) hi = 65535;
                if ($urandom_range(0, 1)) begin
                    r.edge_a = t_field'(lo);
                    r.edge_b = t_field'(hi);
                end else begin
                    r.edge_a = t_field'(hi);
                    r.edge_b = t_field'(lo);
                end
            end
            default: begin
                r.edge_a = t_field'($urandom_range(0, span));
                r.edge_b = t_field'($urandom_range(0, span));
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input t_req r);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_request(r);
    endtask

    task automatic await_idle();
        start <= 1'b0;
        while (pending_windows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_span(input t_pos v);
        await_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        span_cfg = v;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_strobe) begin
            if (pending_windows.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, o_res);
                error_count++;
            end else begin
                want = pending_windows.pop_front();
                compare_field("window_start", want.window_start, o_res.window_start);
                compare_field("window_end", want.window_end, o_res.window_end);
                compare_field("is_best", 16'(want.is_best), 16'(o_res.is_best));
                compare_field("no_window", 16'(want.no_window), 16'(o_res.no_window));
                compare_field("overflow", 16'(want.overflow), 16'(o_res.overflow));
                compare_field("last_window", 16'(want.last_window), 16'(o_res.last_window));
            end
        end
    end

    task automatic test_window_shapes();
        send_request(make_req(1'b0, 0, 0, 1'b1));
        send_request(make_req(1'b1, 300, 100, 1'b0));
        send_request(make_req(1'b1, 250, 350, 1'b0));
        send_request(make_req(1'b1, 40, 40, 1'b0));
        send_request(make_req(1'b1, 90, 0, 1'b1));
        send_request(make_req(1'b0, 16'hFFFF, 16'hFFFF, 1'b0));
        send_request(make_req(1'b1, 65535, 0, 1'b1));
    endtask

    task automatic test_span_extremes();
        write_span(16'd0);
        send_request(make_req(1'b1, 5, 65535, 1'b1));
        write_span(16'd300);
        send_request(make_req(1'b1, 200, 100, 1'b1));
        write_span(16'd1000);
        send_request(make_req(1'b1, 2000, 500, 1'b1));
    endtask

    task automatic test_split_capacity();
        write_span(16'hFFFF);
        for (int k = 0; k < MAX_WINDOWS - 1; k++)
            send_request(make_req(1'b1, 1000 * k + 100, 1000 * k + 200, 1'b0));
        send_request(make_req(1'b1, 30000, 20000, 1'b1));
        send_request(make_req(1'b0, 0, 0, 1'b1));
    endtask

    task automatic test_random_scenes();
        int   left;
        int   len;
        t_pos span;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0, 5:    span = 16'hFFFF;
                1:       span = 16'd0;
                2:       span = 16'd1;
                3:       span = t_pos'($urandom_range(2, 40));
                4:       span = t_pos'($urandom_range(41, 65534));
                6:       span = t_pos'($urandom_range(2, 300));
                default: span = t_pos'($urandom_range(1000, 65534));
            endcase
            if (p >= 6) gaps_on = 1'b0;
            write_span(span);
            left = PHASE_REQUESTS;
            while (left > 0) begin
                len = $urandom_range(1, 24);
                if (len > left) len = left;
                for (int i = 0; i < len; i++)
                    send_request(random_req(i == len - 1));
                left -= len;
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        span_cfg      = 16'hFFFF;
        win_cnt       = 0;
        scene_live    = 1'b0;
        split_dropped = 1'b0;
        gaps_on       = 1'b1;
        error_count   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_window_shapes();
        test_span_extremes();
        test_split_capacity();
        test_random_scenes();
        await_idle();
        if (error_count == 0 && pending_windows.size() == 0) begin
            $display("free_interval_subtractor_core_tb: done, clean");
        end else begin
            $display("free_interval_subtractor_core_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("free_interval_subtractor_core_tb: done, errors");
        $finish;
    end

endmodule
